[src/cnsw_pkg.sv]
// Shared types and constants for the cpio newc stream walker.
// Depends on nothing; imported by cpio_newc_stream_walker.
package cnsw_pkg;

    // Header layout of a newc entry.
    localparam logic [31:0] HDR_LAST    = 32'd109;
    localparam logic [31:0] FSIZE_START = 32'd54;
    localparam logic [31:0] FSIZE_END   = 32'd61;
    localparam logic [31:0] NSIZE_START = 32'd94;
    localparam logic [31:0] NSIZE_END   = 32'd101;
    localparam logic [31:0] TRAILER_LEN = 32'd11;

    // Region codes as they appear on the output.
    typedef enum logic [2:0] {
        REG_HEADER  = 3'd0,
        REG_NAME    = 3'd1,
        REG_NAMEPAD = 3'd2,
        REG_DATA    = 3'd3,
        REG_DATAPAD = 3'd4,
        REG_AFTER   = 3'd5
    } t_region;

    // Walker state, one-hot.
    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_NAME    = 6'b000010,
        PH_NAMEPAD = 6'b000100,
        PH_DATA    = 6'b001000,
        PH_DATAPAD = 6'b010000,
        PH_AFTER   = 6'b100000
    } t_phase;

    // Expected character of the trailer name at a given position.
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h54;  // T
            4'd1:    ch = 8'h52;  // R
            4'd2:    ch = 8'h41;  // A
            4'd3:    ch = 8'h49;  // I
            4'd4:    ch = 8'h4C;  // L
            4'd5:    ch = 8'h45;  // E
            4'd6:    ch = 8'h52;  // R
            4'd7:    ch = 8'h21;  // !
            4'd8:    ch = 8'h21;  // !
            4'd9:    ch = 8'h21;  // !
            default: ch = 8'h00;  // terminating NUL
        endcase
        return ch;
    endfunction

    // Digit rule of the archive format: letters from 'A' upward, else digits.
    function automatic logic [31:0] digit_value(input logic [7:0] c);
        logic [31:0] wide;
        wide = {24'd0, c};
        return (c >= 8'd65) ? (wide - 32'd55) : (wide - 32'd48);
    endfunction

endpackage

[src/cpio_newc_stream_walker.sv]
// Top level of the cpio newc stream walker: tags archive bytes by region.
// Depends on cnsw_pkg for the region codes, phase type and digit helpers.
//
//  channel   dir  handshake           payload
//  s_axis    in   tvalid / tready     tdata = archive byte
//  m_axis    out  tvalid / tready     tdata = byte, sizes; tlast = last of region;
//                                     tuser = region, trailer flag
//
// One byte per cycle unless the output stalls: each accepted byte updates the
// walker state and is written into the output register in the same cycle.
// The input is ready whenever the output register is empty or being drained.
// Reset (synchronous, active low) returns to the header phase with all
// counters cleared. A stall on the output holds the result and the input.
module cpio_newc_stream_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [7:0] out_byte, [39:8] entry_name_size,
                                          // [71:40] entry_file_size
    output logic        o_m_axis_tlast,   // last_of_region
    output logic [3:0]  o_m_axis_tuser    // [2:0] region, [3] is_trailer
);
    import cnsw_pkg::*;

    // Walker state.
    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [1:0]  r_off,   n_off;
    logic [31:0] r_acc,   n_acc;
    logic [31:0] r_nsize, n_nsize;
    logic [31:0] r_fsize, n_fsize;
    logic        r_tmatch, n_tmatch;

    // Output register.
    logic        r_out_valid;
    logic [71:0] r_out_data;
    logic        r_out_last;
    logic [3:0]  r_out_user;

    // Per-item results.
    t_region     w_region;
    logic        w_last;
    logic        w_trl;
    logic [31:0] w_nsz, w_fsz;
    logic        w_moved;
    logic [31:0] w_base, w_hex;
    logic        w_accept;
    logic [7:0]  w_c;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_c             = i_s_axis_tdata;

    // Enter a region, skipping those that are empty for this entry.
    function automatic t_phase enter_region(input t_phase nxt, input logic [1:0] off,
                                            input logic [31:0] nsize,
                                            input logic [31:0] fsize);
        t_phase p;
        p = nxt;
        if (p == PH_NAME && nsize == 32'd0) p = PH_NAMEPAD;
        if (p == PH_NAMEPAD && off == 2'd0) p = PH_DATA;
        if (p == PH_DATA && fsize == 32'd0) p = PH_DATAPAD;
        if (p == PH_DATAPAD && off == 2'd0) p = PH_HEADER;
        return p;
    endfunction

    // Hex field accumulation for the header size fields.
    assign w_base = (r_count == FSIZE_START || r_count == NSIZE_START) ? 32'd0 : r_acc;
    assign w_hex  = {w_base[27:0], 4'd0} + digit_value(w_c);

    // Next-state and result logic for one byte.
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_off    = r_off + 2'd1;
        n_acc    = r_acc;
        n_nsize  = r_nsize;
        n_fsize  = r_fsize;
        n_tmatch = r_tmatch;
        w_region = REG_AFTER;
        w_last   = 1'b0;
        w_trl    = 1'b0;
        w_nsz    = 32'd0;
        w_fsz    = 32'd0;
        w_moved  = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                w_region = REG_HEADER;
                if ((r_count >= FSIZE_START && r_count <= FSIZE_END) ||
                    (r_count >= NSIZE_START && r_count <= NSIZE_END)) begin
                    n_acc = w_hex;
                    if (r_count == FSIZE_END) n_fsize = w_hex;
                    if (r_count == NSIZE_END) n_nsize = w_hex;
                end
                if (r_count == HDR_LAST) begin
                    w_last   = 1'b1;
                    w_nsz    = r_nsize;
                    w_fsz    = r_fsize;
                    n_tmatch = 1'b1;
                    n_phase  = enter_region(PH_NAME, n_off, r_nsize, r_fsize);
                    n_count  = 32'd0;
                    w_moved  = 1'b1;
                end
            end
            PH_NAME: begin
                w_region = REG_NAME;
                if (r_count < TRAILER_LEN && w_c != trailer_char(r_count[3:0]))
                    n_tmatch = 1'b0;
                if (r_count + 32'd1 == r_nsize) begin
                    w_last  = 1'b1;
                    n_count = 32'd0;
                    w_moved = 1'b1;
                    // The match flag must include this byte's comparison.
                    if (n_tmatch && r_nsize >= TRAILER_LEN) begin
                        w_trl   = 1'b1;
                        n_phase = PH_AFTER;
                    end else begin
                        n_phase = enter_region(PH_NAMEPAD, n_off, r_nsize, r_fsize);
                    end
                end
            end
            PH_NAMEPAD: begin
                w_region = REG_NAMEPAD;
                if (n_off == 2'd0) begin
                    w_last  = 1'b1;
                    n_phase = enter_region(PH_DATA, n_off, r_nsize, r_fsize);
                    n_count = 32'd0;
                    w_moved = 1'b1;
                end
            end
            PH_DATA: begin
                w_region = REG_DATA;
                if (r_count + 32'd1 == r_fsize) begin
                    w_last  = 1'b1;
                    n_phase = enter_region(PH_DATAPAD, n_off, r_nsize, r_fsize);
                    n_count = 32'd0;
                    w_moved = 1'b1;
                end
            end
            PH_DATAPAD: begin
                w_region = REG_DATAPAD;
                if (n_off == 2'd0) begin
                    w_last  = 1'b1;
                    n_phase = PH_HEADER;
                    n_count = 32'd0;
                    w_moved = 1'b1;
                end
            end
            default: begin
                w_region = REG_AFTER;
                n_phase  = PH_AFTER;
            end
        endcase
        // Count bytes taken in the region unless it just ended or is the after region.
        if (!w_moved && w_region != REG_AFTER)
            n_count = r_count + 32'd1;
    end

    // State update on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_count  <= 32'd0;
            r_off    <= 2'd0;
            r_acc    <= 32'd0;
            r_nsize  <= 32'd0;
            r_fsize  <= 32'd0;
            r_tmatch <= 1'b1;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_off    <= n_off;
            r_acc    <= n_acc;
            r_nsize  <= n_nsize;
            r_fsize  <= n_fsize;
            r_tmatch <= n_tmatch;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {w_fsz, w_nsz, w_c};
            r_out_last <= w_last;
            r_out_user <= {w_trl, w_region};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule
